// ----- rtl/ddasm_pkg.sv -----
// shared types and constants for the decimal add, subtract and multiply unit
`timescale 1ns / 1ps
package ddasm_pkg;

	typedef logic [3:0] digit_t;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_RSV = 2'd3;

	localparam digit_t DIGIT_MAX = 4'd9;
	localparam digit_t RADIX     = 4'd10;

	typedef enum logic [3:0] {
		CMD_IDLE,
		CMD_LOAD,
		CMD_PREP,
		CMD_ADD,
		CMD_ADD_CARRY,
		CMD_CMP,
		CMD_SUB,
		CMD_MUL_RD,
		CMD_MUL_WR,
		CMD_MUL_CARRY,
		CMD_OUT_RD,
		CMD_OUT_EMIT
	} cmd_t;

	typedef struct packed {
		logic is_mul;
		logic is_sub;
		logic i_last;
		logic j_last;
		logic cmp_done;
		logic k_zero;
	} status_t;

	// quotient and remainder by ten for values below one hundred
	function automatic logic [7:0] dec_split(input logic [6:0] t);
		logic [3:0] q;
		logic [3:0] r;
		q = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (t >= 7'(k * 10)) q = 4'(k);
		end
		r = 4'(t - {q, 3'b000} - 7'({q, 1'b0}));
		return {q, r};
	endfunction

	function automatic digit_t clamp_digit(input digit_t d);
		return (d > DIGIT_MAX) ? DIGIT_MAX : d;
	endfunction

endpackage

// ----- rtl/ddasm_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ddasm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/ddasm_ctrl.sv -----
// sequencing state machine for load, compute and result output
`timescale 1ns / 1ps
module ddasm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               last_digit,
	input  ddasm_pkg::status_t status,
	output logic               busy,
	output ddasm_pkg::cmd_t    cmd
);
	import ddasm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ADD,
		S_ADD_CARRY,
		S_CMP,
		S_SUB,
		S_MUL_RD,
		S_MUL_WR,
		S_MUL_CARRY,
		S_OUT_RD,
		S_OUT_EMIT
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start && last_digit) begin
						state_q <= S_DISPATCH;
						busy_q  <= 1'b1;
					end
				end
				S_DISPATCH: begin
					if (status.is_mul) state_q <= S_MUL_RD;
					else if (status.is_sub) state_q <= S_CMP;
					else state_q <= S_ADD;
				end
				S_ADD: if (status.i_last) state_q <= S_ADD_CARRY;
				S_ADD_CARRY: state_q <= S_OUT_RD;
				S_CMP: if (status.cmp_done) state_q <= S_SUB;
				S_SUB: if (status.i_last) state_q <= S_OUT_RD;
				S_MUL_RD: state_q <= S_MUL_WR;
				S_MUL_WR: state_q <= status.j_last ? S_MUL_CARRY : S_MUL_RD;
				S_MUL_CARRY: state_q <= status.i_last ? S_OUT_RD : S_MUL_RD;
				S_OUT_RD: state_q <= S_OUT_EMIT;
				S_OUT_EMIT: begin
					if (status.k_zero) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_OUT_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		case (state_q)
			S_IDLE:      cmd = start ? CMD_LOAD : CMD_IDLE;
			S_DISPATCH:  cmd = CMD_PREP;
			S_ADD:       cmd = CMD_ADD;
			S_ADD_CARRY: cmd = CMD_ADD_CARRY;
			S_CMP:       cmd = CMD_CMP;
			S_SUB:       cmd = CMD_SUB;
			S_MUL_RD:    cmd = CMD_MUL_RD;
			S_MUL_WR:    cmd = CMD_MUL_WR;
			S_MUL_CARRY: cmd = CMD_MUL_CARRY;
			S_OUT_RD:    cmd = CMD_OUT_RD;
			S_OUT_EMIT:  cmd = CMD_OUT_EMIT;
			default:     cmd = CMD_IDLE;
		endcase
	end

	assign busy = busy_q;

endmodule

// ----- rtl/ddasm_dpath.sv -----
// operand shift stores, digit arithmetic, result ram and output register
`timescale 1ns / 1ps
module ddasm_dpath #(
	parameter int MAX_DIGITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ddasm_pkg::cmd_t    cmd,
	input  logic [1:0]         op_code,
	input  logic               a_negative,
	input  logic               b_negative,
	input  ddasm_pkg::digit_t  a_digit,
	input  ddasm_pkg::digit_t  b_digit,
	input  logic               last_digit,
	output ddasm_pkg::status_t status,
	output logic               result_valid,
	output ddasm_pkg::digit_t  result_digit,
	output logic               result_negative,
	output logic               result_last
);
	import ddasm_pkg::*;

	localparam int DW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int AW = $clog2(2 * MAX_DIGITS);

	digit_t        a_q [MAX_DIGITS];
	digit_t        b_q [MAX_DIGITS];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [1:0]    op_q;
	logic          sa_q;
	logic          sb_q;
	logic [DW-1:0] i_q;
	logic [DW-1:0] j_q;
	digit_t        carry_q;
	logic          a_ge_q;
	logic          neg_q;
	logic [AW-1:0] k_q;
	logic          started_q;
	logic          result_valid_q;
	digit_t        result_digit_q;
	logic          result_negative_q;
	logic          result_last_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	digit_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	digit_t        ram_rdata;

	logic [DW-1:0] nm1;
	logic [DW-1:0] a_idx;
	digit_t        xa;
	digit_t        xb;
	logic          sbe;
	logic [CW-1:0] n_new;
	logic [4:0]    add_t;
	logic          add_c;
	digit_t        big;
	digit_t        small_d;
	logic [4:0]    sub_s;
	logic          sub_b;
	logic [7:0]    prod;
	digit_t        mul_r;
	logic [6:0]    mul_t;
	logic [7:0]    mul_qr;
	logic          emit;
	logic          nonzero;

	assign nm1   = DW'(n_q - CW'(1));
	assign a_idx = (cmd == CMD_MUL_WR) ? j_q : i_q;
	assign xa    = a_q[a_idx];
	assign xb    = b_q[i_q];
	assign sbe   = sb_q ^ (op_q == OP_SUB);
	assign n_new = (cnt_q == CW'(MAX_DIGITS)) ? cnt_q : cnt_q + CW'(1);

	assign add_t = 5'(xa) + 5'(xb) + 5'(carry_q);
	assign add_c = add_t >= 5'(RADIX);

	assign big     = a_ge_q ? xa : xb;
	assign small_d = a_ge_q ? xb : xa;
	assign sub_s   = 5'(small_d) + 5'(carry_q[0]);
	assign sub_b   = 5'(big) < sub_s;

	assign prod   = 8'(xa) * 8'(xb);
	// first row starts from an all-zero partial sum
	assign mul_r  = (i_q == '0) ? 4'd0 : ram_rdata;
	assign mul_t  = 7'(prod) + 7'(mul_r) + 7'(carry_q);
	assign mul_qr = dec_split(mul_t);

	assign nonzero = ram_rdata != 4'd0;
	assign emit    = started_q || nonzero || (k_q == '0);

	always_comb begin
		status.is_mul   = op_q == OP_MUL;
		status.is_sub   = (op_q != OP_MUL) && (sa_q != sbe);
		status.i_last   = i_q == nm1;
		status.j_last   = j_q == nm1;
		status.cmp_done = (xa != xb) || (i_q == '0);
		status.k_zero   = k_q == '0;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(i_q);
		ram_wdata = 4'd0;
		ram_raddr = k_q;
		case (cmd)
			CMD_ADD: begin
				ram_we    = 1'b1;
				ram_wdata = add_c ? 4'(add_t - 5'(RADIX)) : add_t[3:0];
			end
			CMD_ADD_CARRY: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(n_q);
				ram_wdata = carry_q;
			end
			CMD_SUB: begin
				ram_we    = 1'b1;
				ram_wdata = sub_b ? 4'(5'(big) + 5'(RADIX) - sub_s) : 4'(5'(big) - sub_s);
			end
			CMD_MUL_RD: ram_raddr = AW'(i_q) + AW'(j_q);
			CMD_MUL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(i_q) + AW'(j_q);
				ram_wdata = mul_qr[3:0];
			end
			CMD_MUL_CARRY: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(i_q) + AW'(n_q);
				ram_wdata = carry_q;
			end
			default: begin
			end
		endcase
	end

	ddasm_ram #(
		.WIDTH(4),
		.DEPTH(2 * MAX_DIGITS)
	) u_res_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// operand stores shift towards the top, newest digit at index zero
	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			a_q[0] <= clamp_digit(a_digit);
			b_q[0] <= clamp_digit(b_digit);
			for (int k = 1; k < MAX_DIGITS; k++) begin
				a_q[k] <= a_q[k-1];
				b_q[k] <= b_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q             <= '0;
			n_q               <= CW'(1);
			op_q              <= OP_ADD;
			sa_q              <= 1'b0;
			sb_q              <= 1'b0;
			i_q               <= '0;
			j_q               <= '0;
			carry_q           <= 4'd0;
			a_ge_q            <= 1'b1;
			neg_q             <= 1'b0;
			k_q               <= '0;
			started_q         <= 1'b0;
			result_valid_q    <= 1'b0;
			result_digit_q    <= 4'd0;
			result_negative_q <= 1'b0;
			result_last_q     <= 1'b0;
		end else begin
			result_valid_q <= (cmd == CMD_OUT_EMIT) && emit;
			case (cmd)
				CMD_LOAD: begin
					if (cnt_q == '0) begin
						op_q <= (op_code == OP_RSV) ? OP_ADD : op_code;
						sa_q <= a_negative;
						sb_q <= b_negative;
					end
					if (last_digit) begin
						n_q   <= n_new;
						cnt_q <= '0;
					end else begin
						cnt_q <= n_new;
					end
				end
				CMD_PREP: begin
					i_q     <= status.is_sub ? nm1 : '0;
					j_q     <= '0;
					carry_q <= 4'd0;
				end
				CMD_ADD: begin
					carry_q <= {3'b000, add_c};
					i_q     <= i_q + DW'(1);
				end
				CMD_ADD_CARRY: begin
					k_q       <= AW'(n_q);
					neg_q     <= sa_q;
					started_q <= 1'b0;
				end
				CMD_CMP: begin
					if (xa != xb) begin
						a_ge_q  <= xa > xb;
						neg_q   <= (xa > xb) ? sa_q : sbe;
						i_q     <= '0;
						carry_q <= 4'd0;
					end else if (i_q == '0) begin
						a_ge_q  <= 1'b1;
						neg_q   <= sa_q;
						carry_q <= 4'd0;
					end else begin
						i_q <= i_q - DW'(1);
					end
				end
				CMD_SUB: begin
					carry_q <= {3'b000, sub_b};
					i_q     <= i_q + DW'(1);
					if (status.i_last) begin
						k_q       <= AW'(n_q) - AW'(1);
						started_q <= 1'b0;
					end
				end
				CMD_MUL_WR: begin
					carry_q <= mul_qr[7:4];
					j_q     <= j_q + DW'(1);
				end
				CMD_MUL_CARRY: begin
					carry_q <= 4'd0;
					j_q     <= '0;
					if (status.i_last) begin
						k_q       <= AW'(n_q) + AW'(n_q) - AW'(1);
						neg_q     <= sa_q ^ sb_q;
						started_q <= 1'b0;
					end else begin
						i_q <= i_q + DW'(1);
					end
				end
				CMD_OUT_EMIT: begin
					result_digit_q    <= ram_rdata;
					// a lone zero digit is never negative
					result_negative_q <= neg_q && (started_q || nonzero);
					result_last_q     <= k_q == '0;
					if (emit) started_q <= 1'b1;
					if (k_q != '0) k_q <= k_q - AW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign result_valid    = result_valid_q;
	assign result_digit    = result_digit_q;
	assign result_negative = result_negative_q;
	assign result_last     = result_last_q;

	a_out_digit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> result_digit_q <= DIGIT_MAX)
		else $error("result digit out of range");

	a_ram_digit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_wdata <= DIGIT_MAX)
		else $error("digit written to result ram out of range");

	a_carry: assert property (@(posedge clk) disable iff (!arst_n)
		carry_q <= DIGIT_MAX)
		else $error("carry out of range");

	a_last_zero_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_last_q && (result_digit_q == 4'd0)
			&& !$past(started_q)) |-> !result_negative_q)
		else $error("negative zero result");

endmodule

// ----- rtl/decimal_digit_add_sub_multiply_unit.sv -----
// top level of the decimal add, subtract and multiply unit
// Usage:
//   A request carries one digit of each operand, most significant first,
//   and is taken at a rising edge with start high and busy low. op_code and
//   the two signs are sampled on the first digit of an operand pair; the
//   request with last_digit high closes the pair and starts the compute.
//   Requests may come every cycle while busy is low. With n digits loaded
//   (n at most MAX_DIGITS) the compute runs in the result ram through the
//   digit unit: add is a digit pass then a carry write, subtract is a
//   compare scan then a borrow pass, multiply reads and writes each partial
//   product digit plus a carry write per row. Output reads each raw result
//   digit from the ram, then emits it, leading zeros skipped; each digit
//   appears for one cycle with result_valid high, result_last marks the
//   final one. busy is high from the closing request until the final digit
//   is registered.
//   The receiver cannot stall: results are strobed, never held.
//   Reset clears the digit count, held operation and signs; the ram needs
//   no clearing since every entry read was written in the same compute.
`timescale 1ns / 1ps
module decimal_digit_add_sub_multiply_unit #(
	parameter int MAX_DIGITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] op_code,
	input  logic       a_negative,
	input  logic       b_negative,
	input  logic [3:0] a_digit,
	input  logic [3:0] b_digit,
	input  logic       last_digit,
	output logic       result_valid,
	output logic [3:0] result_digit,
	output logic       result_negative,
	output logic       result_last
);
	import ddasm_pkg::*;

	cmd_t    cmd;
	status_t status;

	ddasm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_digit(last_digit),
		.status    (status),
		.busy      (busy),
		.cmd       (cmd)
	);

	ddasm_dpath #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.op_code        (op_code),
		.a_negative     (a_negative),
		.b_negative     (b_negative),
		.a_digit        (a_digit),
		.b_digit        (b_digit),
		.last_digit     (last_digit),
		.status         (status),
		.result_valid   (result_valid),
		.result_digit   (result_digit),
		.result_negative(result_negative),
		.result_last    (result_last)
	);

endmodule

// ----- tb/tb_decimal_digit_add_sub_multiply_unit.sv -----
// testbench for the decimal add, subtract and multiply unit
`timescale 1ns / 1ps
module tb_decimal_digit_add_sub_multiply_unit;
	import ddasm_pkg::*;

	localparam int NDIG = 32;

	typedef struct {
		logic [3:0] digit;
		logic       negative;
		logic       last;
	} dec_result_t;

	class dec_scoreboard;
		dec_result_t pending[$];
		logic [3:0]  a_hold[NDIG];
		logic [3:0]  b_hold[NDIG];
		int          loaded;
		logic [1:0]  op_hold;
		logic        sa_hold;
		logic        sb_hold;
		int          errors;

		function void clear();
			loaded = 0;
			op_hold = OP_ADD;
			sa_hold = 1'b0;
			sb_hold = 1'b0;
			errors = 0;
		endfunction

		// folds one accepted request into the digit stores, predicts on the last digit
		function void note_request(logic [1:0] op, logic an, logic bn, logic [3:0] ad,
				logic [3:0] bd, logic lst);
			logic [3:0] x[NDIG];
			logic [3:0] y[NDIG];
			logic [3:0] res[2*NDIG];
			int n, k, t, carry, borrow, sub;
			logic sa, sb, neg, a_ge;
			dec_result_t r;
			if (loaded == 0) begin
				op_hold = (op == OP_RSV) ? OP_ADD : op;
				sa_hold = an;
				sb_hold = bn;
			end
			ad = (ad > DIGIT_MAX) ? DIGIT_MAX : ad;
			bd = (bd > DIGIT_MAX) ? DIGIT_MAX : bd;
			if (loaded < NDIG) begin
				a_hold[loaded] = ad;
				b_hold[loaded] = bd;
				loaded++;
			end else begin
				for (int i = 0; i < NDIG - 1; i++) begin
					a_hold[i] = a_hold[i+1];
					b_hold[i] = b_hold[i+1];
				end
				a_hold[NDIG-1] = ad;
				b_hold[NDIG-1] = bd;
			end
			if (!lst) return;
			n = loaded;
			for (int i = 0; i < n; i++) begin
				x[i] = a_hold[n-1-i];
				y[i] = b_hold[n-1-i];
			end
			for (int i = 0; i < 2*NDIG; i++) res[i] = 4'd0;
			sa = sa_hold;
			sb = sb_hold;
			if (op_hold == OP_MUL) begin
				for (int i = 0; i < n; i++) begin
					carry = 0;
					for (int j = 0; j < n; j++) begin
						t = int'(res[i+j]) + int'(x[j]) * int'(y[i]) + carry;
						res[i+j] = 4'(t % 10);
						carry = t / 10;
					end
					res[i+n] = 4'(carry);
				end
				neg = sa ^ sb;
				k = 2 * n;
			end else begin
				if (op_hold == OP_SUB) sb = !sb;
				if (sa == sb) begin
					carry = 0;
					for (int i = 0; i < n; i++) begin
						t = int'(x[i]) + int'(y[i]) + carry;
						res[i] = 4'(t % 10);
						carry = t / 10;
					end
					res[n] = 4'(carry);
					neg = sa;
					k = n + 1;
				end else begin
					a_ge = 1'b1;
					for (int i = n - 1; i >= 0; i--) begin
						if (x[i] != y[i]) begin
							a_ge = x[i] > y[i];
							break;
						end
					end
					neg = a_ge ? sa : sb;
					borrow = 0;
					for (int i = 0; i < n; i++) begin
						sub = int'(a_ge ? y[i] : x[i]) + borrow;
						t = int'(a_ge ? x[i] : y[i]);
						if (t >= sub) begin
							res[i] = 4'(t - sub);
							borrow = 0;
						end else begin
							res[i] = 4'(t + 10 - sub);
							borrow = 1;
						end
					end
					k = n;
				end
			end
			while (k > 1 && res[k-1] == 4'd0) k--;
			if (k == 1 && res[0] == 4'd0) neg = 1'b0;
			for (int i = 0; i < k; i++) begin
				r.digit = res[k-1-i];
				r.negative = neg;
				r.last = (i + 1 == k);
				pending = {pending, r};
			end
			loaded = 0;
		endfunction

		function void check_result(logic [3:0] d, logic neg, logic lst);
			dec_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result digit %0d neg %0b last %0b", $time, d, neg, lst);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d !== e.digit || neg !== e.negative || lst !== e.last) begin
				$display("%0t: mismatch expected digit %0d neg %0b last %0b, got %0d %0b %0b",
					$time, e.digit, e.negative, e.last, d, neg, lst);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] op_code;
	logic       a_negative;
	logic       b_negative;
	logic [3:0] a_digit;
	logic [3:0] b_digit;
	logic       last_digit;
	logic       result_valid;
	logic [3:0] result_digit;
	logic       result_negative;
	logic       result_last;

	dec_scoreboard board;
	int idle_pct;
	int cycles = 0;

	decimal_digit_add_sub_multiply_unit #(.MAX_DIGITS(NDIG)) dut (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && start && !busy)
			board.note_request(op_code, a_negative, b_negative, a_digit, b_digit, last_digit);
		if (arst_n && result_valid)
			board.check_result(result_digit, result_negative, result_last);
		if (cycles > 2000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// presents one request and holds it until it is taken
	task automatic send_request(logic [1:0] op, logic an, logic bn, logic [3:0] ad,
			logic [3:0] bd, logic lst);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		op_code <= op;
		a_negative <= an;
		b_negative <= bn;
		a_digit <= ad;
		b_digit <= bd;
		last_digit <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// one operand pair; digits above nine turn up now and then
	task automatic send_pair(logic [1:0] op, int n);
		logic an, bn;
		an = 1'($urandom_range(1));
		bn = 1'($urandom_range(1));
		for (int i = 0; i < n; i++) begin
			send_request(i == 0 ? op : 2'($urandom), i == 0 ? an : 1'($urandom),
				i == 0 ? bn : 1'($urandom),
				($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(9)),
				($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(9)),
				i == n - 1);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		int sent, n;
		board = new();
		board.clear();
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op_code = OP_ADD;
		a_negative = 1'b0;
		b_negative = 1'b0;
		a_digit = 4'd0;
		b_digit = 4'd0;
		last_digit = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, every operation, zero result, clamping, reserved op
		send_request(OP_ADD, 0, 0, 4'd9, 4'd9, 1);
		send_request(OP_SUB, 0, 0, 4'd5, 4'd5, 1);
		send_request(OP_SUB, 1, 0, 4'd0, 4'd0, 1);
		send_request(OP_MUL, 1, 0, 4'd9, 4'd9, 1);
		send_request(OP_MUL, 1, 1, 4'd0, 4'd7, 1);
		send_request(OP_RSV, 1, 1, 4'd15, 4'd10, 1);
		send_request(OP_SUB, 0, 1, 4'd12, 4'd3, 0);
		send_request(OP_ADD, 1, 0, 4'd0, 4'd9, 1);
		send_request(OP_ADD, 0, 1, 4'd1, 4'd0, 0);
		send_request(OP_MUL, 0, 0, 4'd0, 4'd9, 1);
		drain();
		// too many digits: 34 digits drops the oldest two
		for (int i = 0; i < 34; i++)
			send_request(OP_MUL, 0, 1, 4'd9, 4'd9, i == 33);
		drain();

		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 51 : (ph == 2) ? 0 : 32;
			while (sent < (ph + 1) * 79) begin
				n = ($urandom_range(19) == 0) ? NDIG : $urandom_range(1, 4);
				send_pair(2'($urandom), n);
				sent += n;
			end
			drain();
		end
		drain();
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- decimal_digit_add_sub_multiply_unit.f -----
rtl/ddasm_pkg.sv
rtl/ddasm_ram.sv
rtl/ddasm_ctrl.sv
rtl/ddasm_dpath.sv
rtl/decimal_digit_add_sub_multiply_unit.sv
tb/tb_decimal_digit_add_sub_multiply_unit.sv
